/* rtl/cfd_pkg.sv */
// Shared types and constants for the control frame deframer.
// Used by the front, queue, back and top level modules.
package cfd_pkg;

    localparam int PayloadLen = 10;
    localparam int QueueDepth = 2;

    localparam logic [1:0] REG_FRAME_MAGIC   = 2'd0;
    localparam logic [1:0] REG_THROTTLE_MIN  = 2'd1;
    localparam logic [1:0] REG_THROTTLE_MAX  = 2'd2;
    localparam logic [1:0] REG_FRAME_TIMEOUT = 2'd3;

    localparam logic [7:0]  RST_FRAME_MAGIC   = 8'hAB;
    localparam logic [15:0] RST_THROTTLE_MIN  = 16'd900;
    localparam logic [15:0] RST_THROTTLE_MAX  = 16'd2100;
    localparam logic [15:0] RST_FRAME_TIMEOUT = 16'd50;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CSUM_BAD = 3'd1,
        ST_THR_BAD  = 3'd2,
        ST_ARM_BAD  = 3'd3,
        ST_TIMEOUT  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]  frame_magic;
        logic [15:0] throttle_min;
        logic [15:0] throttle_max;
        logic [15:0] frame_timeout;
    } t_cfg;

    // One finished frame or timeout, as handed from front to back
    typedef struct packed {
        logic        timeout;
        logic        csum_ok;
        logic [15:0] throttle;
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [7:0]  armed;
    } t_frame_rec;

endpackage

/* rtl/cfd_front.sv */
// Front end: accepts bytes and ticks, hunts for the start byte, assembles frames and times them out.
// Depends on cfd_pkg; pushes finished frame records into cfd_queue.
module cfd_front
    import cfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic       i_mode,
    input  logic [7:0] i_rx_byte,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_frame_rec o_rec
);

    localparam logic [3:0] LastIdx = 4'(PayloadLen - 1);

    logic        r_collecting, n_collecting;
    logic [3:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_xor, n_xor;
    logic [15:0] r_elapsed, n_elapsed;
    logic [7:0]  r_frame_bytes [PayloadLen-1];

    logic        accept;
    logic        last_byte;
    logic [15:0] elapsed_inc;
    logic        timeout_hit;

    assign o_stall     = i_full;
    assign accept      = i_valid && !i_full;
    assign last_byte   = (r_byte_count == LastIdx);
    assign elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign timeout_hit = (elapsed_inc >= i_cfg.frame_timeout);

    always_comb begin
        n_collecting = r_collecting;
        n_byte_count = r_byte_count;
        n_xor        = r_xor;
        n_elapsed    = r_elapsed;
        o_push       = 1'b0;
        o_rec        = '0;
        if (accept) begin
            if (i_mode) begin
                if (r_collecting) begin
                    if (timeout_hit) begin
                        // drop the partial frame and report a timeout
                        o_push       = 1'b1;
                        o_rec.timeout = 1'b1;
                        n_collecting = 1'b0;
                        n_byte_count = '0;
                        n_xor        = '0;
                        n_elapsed    = '0;
                    end else begin
                        n_elapsed = elapsed_inc;
                    end
                end
            end else if (!r_collecting) begin
                if (i_rx_byte == i_cfg.frame_magic) begin
                    n_collecting = 1'b1;
                    n_byte_count = '0;
                    n_xor        = i_rx_byte;
                    n_elapsed    = '0;
                end
            end else if (last_byte) begin
                // checksum byte closes the frame
                o_push        = 1'b1;
                o_rec.csum_ok = (i_rx_byte == r_xor);
                o_rec.throttle = {r_frame_bytes[1], r_frame_bytes[0]};
                o_rec.roll     = {r_frame_bytes[3], r_frame_bytes[2]};
                o_rec.pitch    = {r_frame_bytes[5], r_frame_bytes[4]};
                o_rec.yaw      = {r_frame_bytes[7], r_frame_bytes[6]};
                o_rec.armed    = r_frame_bytes[8];
                n_collecting  = 1'b0;
                n_byte_count  = '0;
                n_xor         = '0;
                n_elapsed     = '0;
            end else begin
                n_xor        = r_xor ^ i_rx_byte;
                n_byte_count = r_byte_count + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_byte_count <= '0;
            r_xor        <= '0;
            r_elapsed    <= '0;
        end else begin
            r_collecting <= n_collecting;
            r_byte_count <= n_byte_count;
            r_xor        <= n_xor;
            r_elapsed    <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_mode && r_collecting && !last_byte) begin
            r_frame_bytes[r_byte_count] <= i_rx_byte;
        end
    end

endmodule

/* rtl/cfd_queue.sv */
// Short queue of frame records between the front and back ends.
// Depends on cfd_pkg for the record type and depth.
module cfd_queue
    import cfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    input  logic       i_pop,
    output t_frame_rec o_rec,
    output logic       o_full,
    output logic       o_empty
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_frame_rec      r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CntW'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

/* rtl/cfd_back.sv */
// Back end: checks a frame record, sets its status and holds it in the output register.
// Depends on cfd_pkg; pops records from cfd_queue.
module cfd_back
    import cfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_empty,
    input  t_frame_rec  i_rec,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_throttle,
    output logic [15:0] o_roll,
    output logic [15:0] o_pitch,
    output logic [15:0] o_yaw,
    output logic [7:0]  o_armed
);

    logic       r_valid;
    t_status    r_status, status;
    t_frame_rec r_rec;

    assign o_pop = !i_empty && (!r_valid || !i_stall);

    // timeout first, then checksum, then throttle range, then armed flag
    always_comb begin
        if (i_rec.timeout) begin
            status = ST_TIMEOUT;
        end else if (!i_rec.csum_ok) begin
            status = ST_CSUM_BAD;
        end else if (i_rec.throttle < i_cfg.throttle_min ||
                     i_rec.throttle > i_cfg.throttle_max) begin
            status = ST_THR_BAD;
        end else if (i_rec.armed > 8'd1) begin
            status = ST_ARM_BAD;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= status;
            r_rec    <= i_rec;
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_throttle = r_rec.throttle;
    assign o_roll     = r_rec.roll;
    assign o_pitch    = r_rec.pitch;
    assign o_yaw      = r_rec.yaw;
    assign o_armed    = r_rec.armed;

endmodule

/* rtl/control_frame_deframer_core.sv */
// Top level of the control frame deframer: configuration registers and the
// front end, queue and back end. Depends on cfd_pkg and the cfd_* modules.
//
// Takes one item (a received byte or a millisecond tick) in every cycle unless
// stalled. A frame result or a timeout result passes through a two-entry record
// queue and is loaded into the output register when the output is free. That
// queue, between the frame assembler and the checking stage, absorbs output
// stalls. The input stalls only while that queue is full, and then every item
// is held, including those that produce no result.
module control_frame_deframer_core
    import cfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [15:0]        o_throttle,
    output logic signed [15:0] o_roll,
    output logic signed [15:0] o_pitch,
    output logic signed [15:0] o_yaw,
    output logic [7:0]         o_armed
);

    t_cfg       r_cfg;
    t_frame_rec push_rec, pop_rec;
    logic       push, pop, q_full, q_empty;
    logic [15:0] roll_u, pitch_u, yaw_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_magic   <= RST_FRAME_MAGIC;
            r_cfg.throttle_min  <= RST_THROTTLE_MIN;
            r_cfg.throttle_max  <= RST_THROTTLE_MAX;
            r_cfg.frame_timeout <= RST_FRAME_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_MAGIC:   r_cfg.frame_magic   <= i_cfg_data[7:0];
                REG_THROTTLE_MIN:  r_cfg.throttle_min  <= i_cfg_data;
                REG_THROTTLE_MAX:  r_cfg.throttle_max  <= i_cfg_data;
                REG_FRAME_TIMEOUT: r_cfg.frame_timeout <= i_cfg_data;
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    cfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_in_valid),
        .i_mode    (i_mode),
        .i_rx_byte (i_rx_byte),
        .i_full    (q_full),
        .o_stall   (o_in_stall),
        .o_push    (push),
        .o_rec     (push_rec)
    );

    cfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (pop_rec),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (q_empty),
        .i_rec      (pop_rec),
        .o_pop      (pop),
        .i_stall    (i_out_stall),
        .o_valid    (o_out_valid),
        .o_status   (o_status),
        .o_throttle (o_throttle),
        .o_roll     (roll_u),
        .o_pitch    (pitch_u),
        .o_yaw      (yaw_u),
        .o_armed    (o_armed)
    );

    assign o_roll  = $signed(roll_u);
    assign o_pitch = $signed(pitch_u);
    assign o_yaw   = $signed(yaw_u);

endmodule

/* rtl/cfd_checker.sv */
// Port-level checks for the control frame deframer top level.
// Depends on cfd_pkg; bound to control_frame_deframer_core below.
module cfd_checker
    import cfd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_status,
    input logic [15:0]        o_throttle,
    input logic signed [15:0] o_roll,
    input logic signed [15:0] o_pitch,
    input logic signed [15:0] o_yaw,
    input logic [7:0]         o_armed
);

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_CSUM_BAD ||
                         o_status == ST_THR_BAD || o_status == ST_ARM_BAD ||
                         o_status == ST_TIMEOUT))
        else $error("status code out of range");

    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_TIMEOUT) |->
            (o_throttle == 16'd0 && o_roll == 16'sd0 && o_pitch == 16'sd0 &&
             o_yaw == 16'sd0 && o_armed == 8'd0))
        else $error("timeout result carries non-zero fields");

    a_armed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OK || o_status == ST_ARM_BAD)) |->
            ((o_status == ST_OK) == (o_armed <= 8'd1)))
        else $error("armed check does not match armed byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status) &&
                                          $stable(o_throttle)))
        else $error("stalled result changed");

endmodule

bind control_frame_deframer_core cfd_checker u_cfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_throttle  (o_throttle),
    .o_roll      (o_roll),
    .o_pitch     (o_pitch),
    .o_yaw       (o_yaw),
    .o_armed     (o_armed)
);

/* sim/cfd_result_checker.sv */
// Result checker for the control frame deframer: tracks frame assembly from the
// accepted items and compares every accepted result with its prediction.
// Depends on cfd_pkg for register indexes, reset values and status codes.
module cfd_result_checker
    import cfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_mode,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_status,
    input  logic [15:0]        i_throttle,
    input  logic signed [15:0] i_roll,
    input  logic signed [15:0] i_pitch,
    input  logic signed [15:0] i_yaw,
    input  logic [7:0]         i_armed,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status            status;
        logic [15:0]        throttle;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic [7:0]         armed;
    } t_frame_result;

    t_frame_result results_due[$];

    logic [7:0]  magic;
    logic [15:0] thr_min;
    logic [15:0] thr_max;
    logic [15:0] timeout_ticks;

    logic        in_frame;
    logic [3:0]  nbytes;
    logic [7:0]  xsum;
    logic [15:0] ticks;
    logic [7:0]  fbyte [PayloadLen];

    int n_fail = 0;

    function automatic void restart_hunt();
        in_frame = 1'b0;
        nbytes   = '0;
        xsum     = '0;
        ticks    = '0;
    endfunction

    task automatic take_item(input logic mode, input logic [7:0] b);
        t_frame_result r;
        r = '0;
        if (mode) begin
            // ticks only count while a frame is open
            if (in_frame) begin
                if (ticks != 16'hFFFF) begin
                    ticks = ticks + 16'd1;
                end
                if (ticks >= timeout_ticks) begin
                    r.status = ST_TIMEOUT;
                    results_due.push_back(r);
                    restart_hunt();
                end
            end
        end else if (!in_frame) begin
            if (b == magic) begin
                in_frame = 1'b1;
                nbytes   = '0;
                xsum     = b;
                ticks    = '0;
            end
        end else begin
            fbyte[nbytes] = b;
            // the checksum byte itself stays out of the running XOR
            if (int'(nbytes) < PayloadLen - 1) begin
                xsum = xsum ^ b;
            end
            nbytes = nbytes + 4'd1;
            if (int'(nbytes) == PayloadLen) begin
                r.throttle = {fbyte[1], fbyte[0]};
                r.roll     = {fbyte[3], fbyte[2]};
                r.pitch    = {fbyte[5], fbyte[4]};
                r.yaw      = {fbyte[7], fbyte[6]};
                r.armed    = fbyte[8];
                if (fbyte[9] != xsum) begin
                    r.status = ST_CSUM_BAD;
                end else if (r.throttle < thr_min || r.throttle > thr_max) begin
                    r.status = ST_THR_BAD;
                end else if (r.armed > 8'd1) begin
                    r.status = ST_ARM_BAD;
                end else begin
                    r.status = ST_OK;
                end
                results_due.push_back(r);
                restart_hunt();
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_result got;
        t_frame_result want;
        if (!i_rst_n) begin
            magic         = RST_FRAME_MAGIC;
            thr_min       = RST_THROTTLE_MIN;
            thr_max       = RST_THROTTLE_MAX;
            timeout_ticks = RST_FRAME_TIMEOUT;
            restart_hunt();
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.status   = t_status'(i_status);
                got.throttle = i_throttle;
                got.roll     = i_roll;
                got.pitch    = i_pitch;
                got.yaw      = i_yaw;
                got.armed    = i_armed;
                if (results_due.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("%0t: result with none due: status %0d thr %0d roll %0d",
                                 $realtime, i_status, got.throttle, got.roll,
                                 " pitch %0d yaw %0d armed %0d",
                                 got.pitch, got.yaw, got.armed);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (got.status !== want.status || got.throttle !== want.throttle ||
                        got.roll !== want.roll || got.pitch !== want.pitch ||
                        got.yaw !== want.yaw || got.armed !== want.armed) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("%0t: mismatch, expected status %0d thr %0d roll %0d",
                                     $realtime, want.status, want.throttle, want.roll,
                                     " pitch %0d yaw %0d armed %0d",
                                     want.pitch, want.yaw, want.armed);
                            $display("    got status %0d thr %0d roll %0d pitch %0d",
                                     i_status, got.throttle, got.roll, got.pitch,
                                     " yaw %0d armed %0d", got.yaw, got.armed);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_MAGIC:   magic         = i_cfg_data[7:0];
                    REG_THROTTLE_MIN:  thr_min       = i_cfg_data;
                    REG_THROTTLE_MAX:  thr_max       = i_cfg_data;
                    REG_FRAME_TIMEOUT: timeout_ticks = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                take_item(i_mode, i_rx_byte);
            end
        end
        o_pending    = results_due.size();
        o_fail_count = n_fail;
    end

endmodule

/* sim/tb_control_frame_deframer_core.sv */
// Testbench top for control_frame_deframer_core: drives bytes, ticks and
// register settings with random gaps and stalls, and gives the verdict.
// Depends on cfd_pkg, the deframer RTL and cfd_result_checker.
module tb_control_frame_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import cfd_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int WDOG_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_ITEMS   = 160;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_idx;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic [15:0]        throttle;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic [7:0]         armed;

    int fail_count;
    int pending;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_reqs   = 0;
    int n_items     = 0;
    int idle_run    = 0;

    logic [7:0]  cur_magic;
    logic [15:0] cur_min;
    logic [15:0] cur_max;
    logic [15:0] cur_timeout;

    always #HALF_PERIOD clk = ~clk;

    control_frame_deframer_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_mode      (mode),
        .i_rx_byte   (rx_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (status),
        .o_throttle  (throttle),
        .o_roll      (roll),
        .o_pitch     (pitch),
        .o_yaw       (yaw),
        .o_armed     (armed)
    );

    cfd_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_mode       (mode),
        .i_rx_byte    (rx_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_status     (status),
        .i_throttle   (throttle),
        .i_roll       (roll),
        .i_pitch      (pitch),
        .i_yaw        (yaw),
        .i_armed      (armed),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random stalls, or a long hold-off when one is requested
    initial begin : receiver
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_reqs != seen) begin
                seen      = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_run = 0;
        end else begin
            idle_run++;
        end
        if (idle_run >= WDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one item and hold it until accepted; entered and left at a falling edge
    task automatic put_item(input logic m, input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_items++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [7:0] mg, input logic [15:0] lo, hi, tmo);
        // upper data bits of the magic write are junk and must be dropped
        write_reg(REG_FRAME_MAGIC, {8'($urandom), mg});
        write_reg(REG_THROTTLE_MIN, lo);
        write_reg(REG_THROTTLE_MAX, hi);
        write_reg(REG_FRAME_TIMEOUT, tmo);
        cfg_we      <= 1'b0;
        cur_magic   = mg;
        cur_min     = lo;
        cur_max     = hi;
        cur_timeout = tmo;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_frame(input logic [15:0] thr, roll_v, pitch_v, yaw_v,
                              input logic [7:0] arm, flip, input int tick_pct);
        logic [7:0] body [PayloadLen];
        logic [7:0] sum;
        body = '{thr[7:0], thr[15:8], roll_v[7:0], roll_v[15:8], pitch_v[7:0],
                 pitch_v[15:8], yaw_v[7:0], yaw_v[15:8], arm, 8'h00};
        sum = cur_magic;
        for (int i = 0; i < PayloadLen - 1; i++) begin
            sum = sum ^ body[i];
        end
        body[PayloadLen - 1] = sum ^ flip;
        put_item(1'b0, cur_magic);
        for (int i = 0; i < PayloadLen; i++) begin
            if ($urandom_range(99) < tick_pct) begin
                put_item(1'b1, 8'($urandom));
            end
            put_item(1'b0, body[i]);
        end
    endtask

    task automatic send_random_frame(input int tick_pct);
        logic [15:0] thr;
        logic [7:0]  arm;
        logic [7:0]  flip;
        case ($urandom_range(9))
            0: thr = cur_min;
            1: thr = cur_max;
            2: thr = cur_min - 16'd1;
            3: thr = cur_max + 16'd1;
            4: thr = 16'($urandom);
            default: begin
                if (cur_min <= cur_max) begin
                    thr = 16'($urandom_range(cur_max, cur_min));
                end else begin
                    thr = 16'($urandom);
                end
            end
        endcase
        arm  = ($urandom_range(99) < 85) ? 8'($urandom_range(1)) : 8'($urandom);
        flip = ($urandom_range(99) < 88) ? 8'h00 : 8'($urandom_range(255, 1));
        send_frame(thr, 16'($urandom), 16'($urandom), 16'($urandom), arm, flip, tick_pct);
    endtask

    task automatic run_traffic(input int n);
        int stop_at;
        int pick;
        int nticks;
        stop_at = n_items + n;
        while (n_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_random_frame(4);
            end else if (pick < 80) begin
                repeat ($urandom_range(4, 1)) put_item(1'b0, 8'($urandom));
            end else if (pick < 88) begin
                repeat ($urandom_range(3, 1)) put_item(1'b1, 8'($urandom));
            end else begin
                // truncated frame, then ticks towards the timeout
                put_item(1'b0, cur_magic);
                repeat ($urandom_range(9)) put_item(1'b0, 8'($urandom));
                if (cur_timeout > 16'd40) begin
                    nticks = $urandom_range(5);
                end else begin
                    nticks = (cur_timeout == 16'd0) ? 1 : int'(cur_timeout);
                end
                repeat (nticks) put_item(1'b1, 8'($urandom));
            end
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode     = 1'b0;
        rx_byte  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 31;
        rx_idle_pct = 58;
        set_regs(RST_FRAME_MAGIC, RST_THROTTLE_MIN, RST_THROTTLE_MAX, 16'd3);
        // tick while hunting is dropped, as is a stray byte
        put_item(1'b1, 8'hFF);
        put_item(1'b0, 8'h00);
        // open a frame and let it time out
        put_item(1'b0, cur_magic);
        repeat (3) put_item(1'b1, 8'h00);
        // good frame at the top throttle limit with the magic byte inside the payload
        send_frame(16'd2100, 16'h7FFF, 16'h8000, 16'hFFAB, 8'd1, 8'h00, 0);
        send_frame(16'd900, 16'h0000, 16'hFFFF, 16'h0001, 8'd0, 8'h01, 0);
        wait_drained();

        set_regs(RST_FRAME_MAGIC, RST_THROTTLE_MIN, RST_THROTTLE_MAX, RST_FRAME_TIMEOUT);
        run_traffic(PHASE_ITEMS);
        wait_drained();
        set_regs(8'h00, 16'd0, 16'hFFFF, 16'hFFFF);
        run_traffic(PHASE_ITEMS);
        wait_drained();

        tx_idle_pct = 58;
        rx_idle_pct = 31;
        // crossed limits: every complete frame with a good checksum fails the range
        set_regs(8'hFF, 16'd2000, 16'd1000, 16'd1);
        run_traffic(PHASE_ITEMS);
        wait_drained();
        set_regs(8'h55, 16'd1000, 16'd2000, 16'd8);
        run_traffic(PHASE_ITEMS);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_regs(RST_FRAME_MAGIC, 16'd1500, 16'd1500, 16'd0);
        // hold the output while frames keep coming so the input backs up
        hold_reqs++;
        repeat (6) send_random_frame(0);
        run_traffic(PHASE_ITEMS);
        wait_drained();
        set_regs(8'h3C, RST_THROTTLE_MIN, RST_THROTTLE_MAX, 16'd30);
        run_traffic(PHASE_ITEMS);
        wait_drained();

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
